>>> hw/rtl/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared word types and calendar tables for the RTC date check block.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Month codes after clamping.
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Binary date and time word taken on a start.
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_date_in;

    // Packed BCD word handed to the RTC write.
    typedef struct packed {
        logic [7:0] year_bcd;
        logic [4:0] month_bcd;
        logic [5:0] day_bcd;
        logic [2:0] weekday;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
        logic [6:0] second_bcd;
    } t_date_out;

    // Calendar results passed from the checker to the packer.
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
    } t_cal_res;

    // Length of a month in a common year.
    function automatic logic [4:0] f_month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB:                            len = 5'd28;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the months before this one, common year.
    function automatic logic [8:0] f_days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/rdc_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_calendar
// Clamps month and day to the calendar and computes the Gregorian weekday.
// ----------------------------------------------------------------------------
module rdc_calendar (
    input  rdc_pkg::t_date_in i_date,
    output rdc_pkg::t_cal_res o_cal
);

    // Remainder by seven: octal digits fold because eight is one mod seven.
    function automatic logic [2:0] f_mod7(input logic [9:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return r[2:0];
    endfunction

    logic [3:0] month_c;
    logic       leap;
    logic [4:0] lim;
    logic [4:0] day_c;
    logic [8:0] yday;
    logic       ge101;
    logic [7:0] yq;
    logic [9:0] wsum;

    always_comb begin
        if (i_date.month < rdc_pkg::MON_JAN) begin
            month_c = rdc_pkg::MON_JAN;
        end else if (i_date.month > rdc_pkg::MON_DEC) begin
            month_c = rdc_pkg::MON_DEC;
        end else begin
            month_c = i_date.month;
        end

        // Two century years fall in range: year 0 is a leap year, year 100 is not.
        leap = (i_date.year[1:0] == 2'b00) && (i_date.year != 7'd100);

        lim = rdc_pkg::f_month_len(month_c);
        if (leap && (month_c == rdc_pkg::MON_FEB)) begin
            lim = 5'd29;
        end
        day_c = (i_date.day > lim) ? lim : i_date.day;

        yday = rdc_pkg::f_days_before(month_c) + 9'(day_c)
             + 9'(leap && (month_c > rdc_pkg::MON_FEB));

        // Year terms of the weekday sum with the constant parts folded mod 7.
        ge101 = (i_date.year >= 7'd101);
        yq    = (8'(i_date.year) + 8'd3) >> 2;
        wsum  = 10'd5 + 10'(i_date.year) + 10'(yq) + 10'(yday) - 10'(ge101);

        o_cal.month   = month_c;
        o_cal.day     = day_c;
        o_cal.weekday = f_mod7(wsum);
    end

endmodule

>>> hw/rtl/rdc_bcd_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_bcd_pack
// Packs date and time fields as tens and units digits; weekday stays binary.
// ----------------------------------------------------------------------------
module rdc_bcd_pack (
    input  rdc_pkg::t_date_in  i_date,
    input  rdc_pkg::t_cal_res  i_cal,
    output rdc_pkg::t_date_out o_out
);

    // Tens by multiplying with 205/2048, exact for seven-bit values.
    function automatic logic [7:0] f_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    logic [7:0] year_p;
    logic [7:0] month_p;
    logic [7:0] day_p;
    logic [7:0] hour_p;
    logic [7:0] minute_p;
    logic [7:0] second_p;

    always_comb begin
        year_p   = f_bcd(i_date.year);
        month_p  = f_bcd(7'(i_cal.month));
        day_p    = f_bcd(7'(i_cal.day));
        hour_p   = f_bcd(7'(i_date.hour));
        minute_p = f_bcd(7'(i_date.minute));
        second_p = f_bcd(7'(i_date.second));

        o_out.year_bcd   = year_p;
        o_out.month_bcd  = month_p[4:0];
        o_out.day_bcd    = day_p[5:0];
        o_out.weekday    = i_cal.weekday;
        o_out.hour_bcd   = hour_p[5:0];
        o_out.minute_bcd = minute_p[6:0];
        o_out.second_bcd = second_p[6:0];
    end

endmodule

>>> hw/rtl/rtc_date_check_weekday_bcd_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_date_check_weekday_bcd_pack
// Checks a binary date, computes its weekday and packs it as BCD for an RTC.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake        | Word
//  ---------+-----------+------------------+------------------------------
//  date in  | input     | i_start, o_busy  | i_in  (rdc_pkg::t_date_in)
//  BCD out  | output    | o_valid strobe   | o_out (rdc_pkg::t_date_out)
//
// A word is taken at every rising edge where i_start is high and o_busy is
// low. The word is captured in an input register, the calendar check and
// the BCD packing run combinationally in the next cycle, and the result
// register then shows it, with o_valid high for one cycle. One word per
// cycle is sustained; nothing between the input and result registers can
// stall, so o_busy stays low. The receiver cannot stall, so nothing is
// held back. Synchronous active-low reset clears both valid flags; the
// data registers are not reset.
//
// Month values are clamped to the range January to December and the day to
// the length of the clamped month, with a leap February allowing 29. A day
// of zero passes through, and its weekday is that of the previous month's
// last day.
// ----------------------------------------------------------------------------
module rtc_date_check_weekday_bcd_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rdc_pkg::t_date_in   i_in,
    output logic                o_busy,
    output logic                o_valid,
    output rdc_pkg::t_date_out  o_out
);

    logic                r_in_vld;
    logic                n_in_vld;
    rdc_pkg::t_date_in   r_in;
    logic                r_out_vld;
    rdc_pkg::t_date_out  r_out;
    rdc_pkg::t_cal_res   cal;
    rdc_pkg::t_date_out  packed_out;

    // The pipeline always moves, so a new word is welcome every cycle.
    assign o_busy   = 1'b0;
    assign n_in_vld = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    // Data registers load only with a live word.
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_in <= i_in;
        end
        if (r_in_vld) begin
            r_out <= packed_out;
        end
    end

    rdc_calendar u_calendar (
        .i_date (r_in),
        .o_cal  (cal)
    );

    rdc_bcd_pack u_bcd_pack (
        .i_date (r_in),
        .i_cal  (cal),
        .o_out  (packed_out)
    );

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // Every accepted word raises o_valid after the input and result registers.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("accepted word did not appear two cycles later");

    // A rising result strobe never appears without a matching earlier start.
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_start, 2))
        else $error("result strobe without a matching start");

    // The weekday is always one of the seven days.
    a_weekday : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.weekday != 3'd7))
        else $error("weekday out of range");

    // The month leaves clamped, between January and December in BCD.
    a_month : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.month_bcd >= 5'h01) && (o_out.month_bcd <= 5'h12)
                     && (o_out.month_bcd[3:0] <= 4'd9)))
        else $error("month not clamped");

    // The clamped day is never above 31 and its units digit is valid BCD.
    a_day : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.day_bcd <= 6'h31) && (o_out.day_bcd[3:0] <= 4'd9)))
        else $error("day not clamped");

endmodule
